@@ sv/ihre_pkg.sv @@
package ihre_pkg;

    // Field widths fixed by the register map and the item format
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 25;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_LEN  = 2'd1;
    localparam logic [1:0] REG_KIND = 2'd2;
    localparam logic [1:0] REG_EOF  = 2'd3;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Last character index of each output section
    localparam logic [3:0] LAST_EXT = 4'd15;  // :02000004hhllcc\n
    localparam logic [3:0] LAST_HDR = 4'd8;   // :nnaaaatt
    localparam logic [3:0] LAST_DAT = 4'd1;   // dd
    localparam logic [3:0] LAST_CLS = 4'd2;   // cc\n
    localparam logic [3:0] LAST_EOF = 4'd11;  // :00000001FF\n

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] TYPE_EXT   = 8'h04;
    localparam logic [7:0] TYPE_EOF   = 8'h01;
    localparam logic [7:0] EXT_COUNT  = 8'h02;
    localparam logic [7:0] EOF_SUM    = 8'hFF;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [7:0]        kind;
        logic              eof;
    } t_cfg;

    // One classified input byte: which sections to print and their fields
    typedef struct packed {
        logic        ext;
        logic [15:0] upper;
        logic [7:0]  ext_sum;
        logic        hdr;
        logic [7:0]  cnt;
        logic [7:0]  ahi;
        logic [7:0]  alo;
        logic [7:0]  kind;
        logic [7:0]  data;
        logic        close;
        logic [7:0]  csum;
        logic        eof;
        logic        last;
    } t_cmd;

    typedef enum logic [4:0] {
        SEC_EXT = 5'b00001,
        SEC_HDR = 5'b00010,
        SEC_DAT = 5'b00100,
        SEC_CLS = 5'b01000,
        SEC_EOF = 5'b10000
    } t_sec;

    // Upper-case ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'h0, n};
        end else begin
            r = 8'h37 + {4'h0, n};
        end
        return r;
    endfunction

endpackage

@@ sv/ihre_front.sv @@
module ihre_front #(
    parameter int RECORD_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ihre_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_room,
    output logic              o_ready,
    output logic              o_push,
    output ihre_pkg::t_cmd    o_cmd
);

    localparam int CW = $clog2(RECORD_BYTES + 1);

    logic [ihre_pkg::LEN_W-1:0] r_pos;
    logic [CW-1:0]              r_left;
    logic [7:0]                 r_sum;
    logic [15:0]                r_upper;

    logic [ihre_pkg::LEN_W-1:0]  len;
    logic [ihre_pkg::ADDR_W-1:0] addr;
    logic [ihre_pkg::LEN_W-1:0]  rem;
    logic [CW-1:0]               cnt;
    logic                        open;
    logic                        ext;
    logic [7:0]                  hdr_sum;
    logic [7:0]                  sum_after;
    logic [CW-1:0]               left_after;
    logic [ihre_pkg::LEN_W:0]    pos_inc;
    logic                        last;
    logic                        close;
    logic [7:0]                  ext_raw;

    assign o_ready = i_room;
    assign o_push  = i_valid && i_room;

    // Classify the byte against the open record
    always_comb begin
        len     = (i_cfg.len == '0) ? ihre_pkg::LEN_W'(1) : i_cfg.len;
        open    = (r_left == '0);
        addr    = i_cfg.base + ihre_pkg::ADDR_W'(r_pos);
        rem     = (len > r_pos) ? (len - r_pos) : ihre_pkg::LEN_W'(1);
        cnt     = (rem < ihre_pkg::LEN_W'(RECORD_BYTES)) ? rem[CW-1:0] : CW'(RECORD_BYTES);
        ext     = open && (addr[31:16] != r_upper);
        hdr_sum = 8'(cnt) + addr[15:8] + addr[7:0] + i_cfg.kind;
        sum_after  = (open ? hdr_sum : r_sum) + i_data_byte;
        left_after = (open ? cnt : r_left) - CW'(1);
        pos_inc    = {1'b0, r_pos} + (ihre_pkg::LEN_W + 1)'(1);
        last       = (pos_inc >= {1'b0, len});
        close      = (left_after == '0) || last;
        ext_raw    = ihre_pkg::EXT_COUNT + ihre_pkg::TYPE_EXT + addr[31:24] + addr[23:16];
    end

    always_comb begin
        o_cmd.ext     = ext;
        o_cmd.upper   = addr[31:16];
        o_cmd.ext_sum = 8'h00 - ext_raw;
        o_cmd.hdr     = open;
        o_cmd.cnt     = 8'(cnt);
        o_cmd.ahi     = addr[15:8];
        o_cmd.alo     = addr[7:0];
        o_cmd.kind    = i_cfg.kind;
        o_cmd.data    = i_data_byte;
        o_cmd.close   = close;
        o_cmd.csum    = 8'h00 - sum_after;
        o_cmd.eof     = last && i_cfg.eof;
        o_cmd.last    = last;
    end

    // Record and image bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_left  <= '0;
            r_sum   <= '0;
            r_upper <= '0;
        end else if (o_push) begin
            r_pos  <= last ? '0 : pos_inc[ihre_pkg::LEN_W-1:0];
            r_left <= close ? '0 : left_after;
            r_sum  <= close ? '0 : sum_after;
            if (last) begin
                r_upper <= '0;
            end else if (ext) begin
                r_upper <= addr[31:16];
            end
        end
    end

endmodule

@@ sv/ihre_fifo.sv @@
module ihre_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ihre_pkg::t_cmd i_cmd,
    output logic           o_room,
    input  logic           i_pop,
    output ihre_pkg::t_cmd o_cmd,
    output logic           o_valid
);

    ihre_pkg::t_cmd              r_mem [ihre_pkg::QDEPTH];
    logic [ihre_pkg::QAW-1:0]    r_wr;
    logic [ihre_pkg::QAW-1:0]    r_rd;
    logic [ihre_pkg::QAW:0]      r_cnt;

    assign o_room  = (r_cnt != (ihre_pkg::QAW + 1)'(ihre_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + ihre_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + ihre_pkg::QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (ihre_pkg::QAW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (ihre_pkg::QAW + 1)'(1);
            end
        end
    end

endmodule

@@ sv/ihre_back.sv @@
module ihre_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ihre_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_text_char,
    output logic           o_run_last,
    output logic           o_image_done
);

    ihre_pkg::t_cmd r_cmd;
    ihre_pkg::t_sec r_sec;
    logic           r_busy;
    logic [3:0]     r_idx;
    logic           r_ovalid;
    logic [7:0]     r_char;
    logic           r_run_last;
    logic           r_done;

    logic           adv;
    logic           seg_end;
    logic           has_next;
    ihre_pkg::t_sec nxt_sec;
    ihre_pkg::t_sec first_sec;
    logic           cmd_end;
    logic [3:0]     idx_m1;
    logic [2:0]     k;
    logic [7:0]     sel_byte;
    logic           hi_nib;
    logic           lit;
    logic [7:0]     lit_char;
    logic [7:0]     cur_char;

    assign adv       = r_busy && (!r_ovalid || i_ready);
    assign cmd_end   = seg_end && !has_next;
    assign o_cmd_pop = i_cmd_valid && (!r_busy || (adv && cmd_end));
    assign first_sec = i_cmd.ext ? ihre_pkg::SEC_EXT :
                       (i_cmd.hdr ? ihre_pkg::SEC_HDR : ihre_pkg::SEC_DAT);

    // Section order and its end
    always_comb begin
        seg_end  = 1'b0;
        has_next = 1'b0;
        nxt_sec  = ihre_pkg::SEC_DAT;
        case (r_sec)
            ihre_pkg::SEC_EXT: begin
                seg_end  = (r_idx == ihre_pkg::LAST_EXT);
                has_next = 1'b1;
                nxt_sec  = ihre_pkg::SEC_HDR;
            end
            ihre_pkg::SEC_HDR: begin
                seg_end  = (r_idx == ihre_pkg::LAST_HDR);
                has_next = 1'b1;
                nxt_sec  = ihre_pkg::SEC_DAT;
            end
            ihre_pkg::SEC_DAT: begin
                seg_end  = (r_idx == ihre_pkg::LAST_DAT);
                has_next = r_cmd.close;
                nxt_sec  = ihre_pkg::SEC_CLS;
            end
            ihre_pkg::SEC_CLS: begin
                seg_end  = (r_idx == ihre_pkg::LAST_CLS);
                has_next = r_cmd.eof;
                nxt_sec  = ihre_pkg::SEC_EOF;
            end
            ihre_pkg::SEC_EOF: begin
                seg_end  = (r_idx == ihre_pkg::LAST_EOF);
            end
            default: begin
                seg_end = 1'b1;
            end
        endcase
    end

    // Character of the current position
    always_comb begin
        idx_m1   = r_idx - 4'd1;
        k        = idx_m1[3:1];
        sel_byte = 8'h00;
        hi_nib   = r_idx[0];
        lit      = 1'b0;
        lit_char = ihre_pkg::CH_COLON;
        case (r_sec)
            ihre_pkg::SEC_EXT: begin
                lit      = (r_idx == 4'd0) || (r_idx == ihre_pkg::LAST_EXT);
                lit_char = (r_idx == 4'd0) ? ihre_pkg::CH_COLON : ihre_pkg::CH_NEWLINE;
                case (k)
                    3'd0:    sel_byte = ihre_pkg::EXT_COUNT;
                    3'd3:    sel_byte = ihre_pkg::TYPE_EXT;
                    3'd4:    sel_byte = r_cmd.upper[15:8];
                    3'd5:    sel_byte = r_cmd.upper[7:0];
                    3'd6:    sel_byte = r_cmd.ext_sum;
                    default: sel_byte = 8'h00;
                endcase
            end
            ihre_pkg::SEC_HDR: begin
                lit = (r_idx == 4'd0);
                case (k)
                    3'd0:    sel_byte = r_cmd.cnt;
                    3'd1:    sel_byte = r_cmd.ahi;
                    3'd2:    sel_byte = r_cmd.alo;
                    default: sel_byte = r_cmd.kind;
                endcase
            end
            ihre_pkg::SEC_DAT: begin
                sel_byte = r_cmd.data;
                hi_nib   = (r_idx == 4'd0);
            end
            ihre_pkg::SEC_CLS: begin
                sel_byte = r_cmd.csum;
                hi_nib   = (r_idx == 4'd0);
                lit      = (r_idx == ihre_pkg::LAST_CLS);
                lit_char = ihre_pkg::CH_NEWLINE;
            end
            ihre_pkg::SEC_EOF: begin
                lit      = (r_idx == 4'd0) || (r_idx == ihre_pkg::LAST_EOF);
                lit_char = (r_idx == 4'd0) ? ihre_pkg::CH_COLON : ihre_pkg::CH_NEWLINE;
                case (k)
                    3'd3:    sel_byte = ihre_pkg::TYPE_EOF;
                    3'd4:    sel_byte = ihre_pkg::EOF_SUM;
                    default: sel_byte = 8'h00;
                endcase
            end
            default: begin
                sel_byte = 8'h00;
            end
        endcase
        cur_char = lit ? lit_char
                       : ihre_pkg::hex_char(hi_nib ? sel_byte[7:4] : sel_byte[3:0]);
    end

    // Sequencer: one character per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sec  <= ihre_pkg::SEC_DAT;
            r_idx  <= '0;
        end else if (o_cmd_pop) begin
            r_busy <= 1'b1;
            r_sec  <= first_sec;
            r_idx  <= '0;
        end else if (adv) begin
            if (!seg_end) begin
                r_idx <= r_idx + 4'd1;
            end else if (has_next) begin
                r_sec <= nxt_sec;
                r_idx <= '0;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char     <= cur_char;
            r_run_last <= cmd_end;
            r_done     <= cmd_end && r_cmd.last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_text_char  = r_char;
    assign o_run_last   = r_run_last;
    assign o_image_done = r_done;

endmodule

@@ sv/intel_hex_record_encoder.sv @@
// Intel HEX encoder: image bytes go in on the i_valid/o_ready channel and the
// ASCII text of the hex file comes out one character per transfer on
// o_valid/i_ready. A front stage takes one byte per cycle while its four-entry
// command queue has room and works out the record fields; the back stage
// prints one character per cycle unless i_ready stalls it, so the sustained
// rate is set by the character count: 2 for a byte inside a record, 9 more
// for a byte that opens one and 3 for the byte that closes it (44 characters
// per full 16-byte record, about 2.75 per byte), plus 16 for an extended linear
// address record and 12 for the EOF record. o_run_last marks the last
// character of each byte's output and o_image_done the final character of
// the image. Write the registers over APB only while the block is idle.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_text_char,
    output logic        o_run_last,
    output logic        o_image_done
);

    ihre_pkg::t_cfg r_cfg;
    ihre_pkg::t_cmd front_cmd;
    ihre_pkg::t_cmd queue_cmd;
    logic           push;
    logic           room;
    logic           pop;
    logic           queue_valid;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base <= '0;
            r_cfg.len  <= ihre_pkg::LEN_W'(1);
            r_cfg.kind <= '0;
            r_cfg.eof  <= 1'b1;
        end else if (wr_en) begin
            case (paddr[3:2])
                ihre_pkg::REG_BASE: r_cfg.base <= pwdata;
                ihre_pkg::REG_LEN:  r_cfg.len  <= pwdata[ihre_pkg::LEN_W-1:0];
                ihre_pkg::REG_KIND: r_cfg.kind <= pwdata[7:0];
                ihre_pkg::REG_EOF:  r_cfg.eof  <= pwdata[0];
                default:            r_cfg.eof  <= r_cfg.eof;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            ihre_pkg::REG_BASE: prdata = r_cfg.base;
            ihre_pkg::REG_LEN:  prdata = 32'(r_cfg.len);
            ihre_pkg::REG_KIND: prdata = {24'h0, r_cfg.kind};
            ihre_pkg::REG_EOF:  prdata = {31'h0, r_cfg.eof};
            default:            prdata = '0;
        endcase
    end

    ihre_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_room      (room),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    ihre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_room  (room),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid)
    );

    ihre_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (queue_cmd),
        .i_cmd_valid  (queue_valid),
        .o_cmd_pop    (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_char  (o_text_char),
        .o_run_last   (o_run_last),
        .o_image_done (o_image_done)
    );

endmodule

@@ verif/intel_hex_record_encoder_tb.sv @@
module intel_hex_record_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 600000;
    localparam int  RANDOM_BYTES = 380;
    localparam int  SHOW_LIMIT   = 10;
    localparam logic [31:0] MAX_LEN = 32'd16777216;

    // Expected text stream of the encoder, built byte by byte
    class hex_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       run_last;
            logic       image_done;
        } t_text_item;

        t_text_item  text_q[$];
        logic [31:0] base;
        logic [24:0] length;
        logic [7:0]  kind;
        logic        eof_on;
        logic [24:0] pos;
        logic [4:0]  left;
        logic [7:0]  sum;
        logic [15:0] upper_sent;
        int          fails;

        function new();
            base       = '0;
            length     = 25'd1;
            kind       = '0;
            eof_on     = 1'b1;
            pos        = '0;
            left       = '0;
            sum        = '0;
            upper_sent = '0;
            fails      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                ihre_pkg::REG_BASE: base   = val;
                ihre_pkg::REG_LEN:  length = val[24:0];
                ihre_pkg::REG_KIND: kind   = val[7:0];
                ihre_pkg::REG_EOF:  eof_on = val[0];
                default: ;
            endcase
        endfunction

        function void push_char(logic [7:0] c);
            t_text_item t;
            t.ch         = c;
            t.run_last   = 1'b0;
            t.image_done = 1'b0;
            text_q.push_back(t);
        endfunction

        function void push_hex(logic [7:0] b);
            logic [7:0] hi;
            logic [7:0] lo;
            hi = {4'h0, b[7:4]};
            lo = {4'h0, b[3:0]};
            push_char(hi < 8'd10 ? 8'h30 + hi : 8'h41 + hi - 8'd10);
            push_char(lo < 8'd10 ? 8'h30 + lo : 8'h41 + lo - 8'd10);
        endfunction

        // two's-complement checksum then end of line
        function void push_csum(logic [7:0] s);
            push_hex(~s + 8'd1);
            push_char(ihre_pkg::CH_NEWLINE);
        endfunction

        // Predict every character one accepted image byte causes
        function void note_byte(logic [7:0] b);
            logic [24:0] len;
            logic [31:0] addr;
            logic [24:0] rem;
            logic [7:0]  cnt;
            logic        last;
            int          n;
            len = (length == 0) ? 25'd1 : length;
            if (left == 0) begin
                addr = base + {7'd0, pos};
                // extended linear address record on a new upper half
                if (addr[31:16] != upper_sent) begin
                    push_char(ihre_pkg::CH_COLON);
                    push_hex(ihre_pkg::EXT_COUNT);
                    push_hex(8'h00);
                    push_hex(8'h00);
                    push_hex(ihre_pkg::TYPE_EXT);
                    push_hex(addr[31:24]);
                    push_hex(addr[23:16]);
                    push_csum(ihre_pkg::EXT_COUNT + ihre_pkg::TYPE_EXT
                              + addr[31:24] + addr[23:16]);
                    upper_sent = addr[31:16];
                end
                rem = (len > pos) ? len - pos : 25'd1;
                cnt = (rem < 25'd16) ? rem[7:0] : 8'd16;
                push_char(ihre_pkg::CH_COLON);
                push_hex(cnt);
                push_hex(addr[15:8]);
                push_hex(addr[7:0]);
                push_hex(kind);
                sum  = cnt + addr[15:8] + addr[7:0] + kind;
                left = cnt[4:0];
            end
            push_hex(b);
            sum  = sum + b;
            left = left - 5'd1;
            last = ({1'b0, pos} + 26'd1) >= {1'b0, len};
            pos  = pos + 25'd1;
            // close on a full record, or early at the image end
            if (left == 0 || last) begin
                push_csum(sum);
                left = '0;
                sum  = '0;
            end
            if (last) begin
                if (eof_on) begin
                    push_char(ihre_pkg::CH_COLON);
                    push_hex(8'h00);
                    push_hex(8'h00);
                    push_hex(8'h00);
                    push_hex(ihre_pkg::TYPE_EOF);
                    push_hex(ihre_pkg::EOF_SUM);
                    push_char(ihre_pkg::CH_NEWLINE);
                end
                pos        = '0;
                upper_sent = '0;
            end
            n = text_q.size() - 1;
            text_q[n].run_last = 1'b1;
            if (last) text_q[n].image_done = 1'b1;
        endfunction

        function void report(string what);
            fails++;
            if (fails <= SHOW_LIMIT) $display("ERROR: %s", what);
        endfunction

        function void check_char(logic [7:0] ch, logic rl, logic done);
            t_text_item want;
            if (text_q.size() == 0) begin
                report($sformatf("unexpected char %h run_last %b done %b", ch, rl, done));
                return;
            end
            want = text_q.pop_front();
            if (want.ch !== ch || want.run_last !== rl || want.image_done !== done)
                report($sformatf("expected char %h run_last %b done %b, got %h %b %b",
                                 want.ch, want.run_last, want.image_done, ch, rl, done));
        endfunction

        function void report_unfinished();
            if (text_q.size() != 0)
                report($sformatf("%0d characters never came out", text_q.size()));
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte  = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_run_last;
    logic        o_image_done;

    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 53;
    int          random_sent   = 0;

    hex_scoreboard sb = new;

    intel_hex_record_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_char  (o_text_char),
        .o_run_last   (o_run_last),
        .o_image_done (o_image_done)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_char(o_text_char, o_run_last, o_image_done);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // APB write: setup then access phase
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one input transfer, with optional leading gap
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b);
    endtask

    // stop sending and let every expected character drain
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.text_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] base, input logic [31:0] len,
                             input logic [7:0] kind, input logic eof);
        write_reg(ihre_pkg::REG_BASE, base);
        write_reg(ihre_pkg::REG_LEN, len);
        write_reg(ihre_pkg::REG_KIND, {24'd0, kind});
        write_reg(ihre_pkg::REG_EOF, {31'd0, eof});
    endtask

    task automatic random_image();
        logic [31:0] base;
        logic [31:0] len;
        logic [7:0]  kind;
        int          k;
        case ($urandom_range(9))
            0, 1:    base = {16'($urandom_range(16'hFFFF)),
                             16'(16'hFFFF - $urandom_range(40))};
            2:       base = 32'hFFFF_FFFF - $urandom_range(40);
            3:       base = '0;
            default: base = $urandom;
        endcase
        case ($urandom_range(19))
            0:       len = 0;
            1, 2:    len = $urandom_range(41, 70);
            default: len = $urandom_range(1, 40);
        endcase
        kind = ($urandom_range(9) < 7) ? 8'h00 : 8'($urandom);
        if ($urandom_range(7) == 0) begin
            // image cut short: huge length, then shrink to at most the position
            configure(base, MAX_LEN, kind, 1'($urandom));
            k = $urandom_range(1, 30);
            repeat (k) send_byte(8'($urandom));
            drain();
            write_reg(ihre_pkg::REG_LEN, $urandom_range(0, k));
            send_byte(8'($urandom));
            random_sent += k + 1;
        end else begin
            configure(base, len, kind, 1'($urandom));
            repeat ((len == 0) ? 1 : len) send_byte(8'($urandom));
            random_sent += (len == 0) ? 1 : len;
        end
        drain();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: one byte, EOF on
        send_byte(8'h00);
        drain();

        // top address, zero length acts as one, signature type, no EOF
        configure(32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b0);
        send_byte(8'hFF);
        drain();

        // two records across a 64K boundary
        configure(32'h7FFF_FFF0, 32'd17, 8'h05, 1'b1);
        for (int i = 0; i < 17; i++)
            send_byte(i == 0 ? 8'h00 : i == 1 ? 8'hFF : 8'($urandom));
        drain();

        // length shrunk mid-record closes it early
        configure(32'd0, MAX_LEN, 8'h00, 1'b1);
        repeat (3) send_byte(8'($urandom));
        drain();
        write_reg(ihre_pkg::REG_LEN, 32'd2);
        send_byte(8'h5A);
        drain();

        // random images, three idling regimes
        while (random_sent < RANDOM_BYTES) begin
            if (random_sent < RANDOM_BYTES / 3) begin
                send_idle_pct = 12;
                recv_idle_pct = 53;
            end else if (random_sent < 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 53;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_image();
        end

        repeat (20) @(posedge i_clk);
        sb.report_unfinished();
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
